// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

   localparam int OPND_BITS = 32;
   localparam int RES_BITS  = 64;
   localparam int CMD_BITS  = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD      = 3'd0,
      CMD_SUB      = 3'd1,
      CMD_MUL      = 3'd2,
      CMD_DIV      = 3'd3,
      CMD_SIMPLIFY = 3'd4
   } command_type;

   typedef struct packed {
      logic                       start;
      logic signed [RES_BITS-1:0] dividend;
      logic signed [RES_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [RES_BITS-1:0] quotient;
      logic signed [RES_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/core/rau_if.sv =====
interface rau_req_if import rau_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [CMD_BITS-1:0]         command;
   logic signed [OPND_BITS-1:0] a_num;
   logic signed [OPND_BITS-1:0] a_den;
   logic signed [OPND_BITS-1:0] b_num;
   logic signed [OPND_BITS-1:0] b_den;

   modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [RES_BITS-1:0] res_num;
   logic signed [RES_BITS-1:0] res_den;
   logic                       res_valid;

   modport source (output valid, res_num, res_den, res_valid, input ready);
   modport sink (input valid, res_num, res_den, res_valid, output ready);
endinterface

// ===== rtl/core/rau_div.sv =====
module rau_div import rau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIN
   } div_state_type;

   div_state_type         state_ff;
   logic [5:0]            cnt_ff;
   logic                  neg_q_ff;
   logic                  neg_r_ff;
   logic [RES_BITS-1:0]   dvs_ff;
   logic [RES_BITS:0]     rem_ff;
   logic [RES_BITS-1:0]   quo_ff;
   div_rsp_type           rsp_ff;

   logic [RES_BITS:0]     shifted;
   logic                  ge;
   logic [RES_BITS:0]     rem_in;
   logic [RES_BITS-1:0]   quo_in;

   always_comb begin
      shifted = {rem_ff[RES_BITS-1:0], quo_ff[RES_BITS-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? shifted - {1'b0, dvs_ff} : shifted;
      quo_in  = {quo_ff[RES_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= D_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= state_ff == D_FIN;
         case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  neg_q_ff <= req.dividend[RES_BITS-1] ^ req.divisor[RES_BITS-1];
                  neg_r_ff <= req.dividend[RES_BITS-1];
                  quo_ff   <= req.dividend[RES_BITS-1] ? -req.dividend : req.dividend;
                  dvs_ff   <= req.divisor[RES_BITS-1] ? -req.divisor : req.divisor;
                  rem_ff   <= '0;
                  cnt_ff   <= '1;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == '0) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               rsp_ff.quotient  <= neg_q_ff ? -quo_ff : quo_ff;
               rsp_ff.remainder <= neg_r_ff ? -rem_ff[RES_BITS-1:0] : rem_ff[RES_BITS-1:0];
               state_ff         <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/core/rational_arithmetic_unit_core.sv =====
// Channel   Dir   Words carried
// req       in    command, a_num, a_den, b_num, b_den
// rsp       out   res_num, res_den, res_valid
//
// Each word is taken in the idle state and is worked on alone; req.ready is low until
// the result has moved to the output register. Multiply and divide pass through the
// cross-multiply states; add or subtract with equal or zero denominators, invalid
// simplify and unused commands go straight to the result state. Other words run Euclid
// through one shared radix-2 divider, with an issue state before each division.
// Reset is synchronous and clears the sequencer and the output valid flag.
// A result waiting on rsp does not stop the next word from being accepted; that word's
// result then waits in the last sequencer state until the output register frees.
module rational_arithmetic_unit_core import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = 32
) (
   input logic  clock,
   input logic  reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   localparam int MW = OPERAND_WIDTH + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_GCD, S_GCD_WAIT, S_LCM_MUL, S_LCM_DIV, S_LCM_WAIT,
      S_Q1_DIV, S_Q1_WAIT, S_TA_MUL, S_Q2_DIV, S_Q2_WAIT, S_TB_MUL, S_SUM,
      S_XMUL1, S_XMUL2, S_SN_DIV, S_SN_WAIT, S_SD_DIV, S_SD_WAIT, S_FIX, S_DONE
   } state_type;

   state_type                       state_ff;
   logic [CMD_BITS-1:0]             cmd_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [RES_BITS-1:0]      gx_ff, gy_ff, prod_ff, lcm_ff, q_ff, ta_ff, tb_ff;
   logic signed [RES_BITS-1:0]      num_ff, den_ff;
   logic                            rsp_valid_ff;
   logic signed [RES_BITS-1:0]      rsp_num_ff, rsp_den_ff;

   logic signed [MW-1:0]            mul_a, mul_b;
   logic signed [2*MW-1:0]          mul_p;
   logic signed [RES_BITS-1:0]      mul_res;
   logic signed [RES_BITS-1:0]      g_abs;
   div_req_type                     dreq;
   div_rsp_type                     drsp;

   rau_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign g_abs   = gx_ff[RES_BITS-1] ? -gx_ff : gx_ff;
   assign mul_p   = mul_a * mul_b;
   assign mul_res = RES_BITS'(mul_p);

   always_comb begin
      mul_a = MW'(ad_ff);
      mul_b = MW'(bd_ff);
      case (state_ff)
         S_TA_MUL: begin
            mul_a = MW'(q_ff);
            mul_b = MW'(an_ff);
         end
         S_TB_MUL: begin
            mul_a = MW'(q_ff);
            mul_b = MW'(bn_ff);
         end
         S_XMUL1: begin
            mul_a = MW'(an_ff);
            mul_b = (cmd_ff == CMD_MUL) ? MW'(bn_ff) : MW'(bd_ff);
         end
         S_XMUL2: begin
            mul_a = MW'(ad_ff);
            mul_b = (cmd_ff == CMD_MUL) ? MW'(bd_ff) : MW'(bn_ff);
         end
         default: begin
            mul_a = MW'(ad_ff);
            mul_b = MW'(bd_ff);
         end
      endcase
   end

   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = gx_ff;
      dreq.divisor  = gy_ff;
      case (state_ff)
         S_GCD: begin
            dreq.start = gy_ff != '0;
         end
         S_LCM_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = prod_ff;
            dreq.divisor  = gx_ff;
         end
         S_Q1_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = lcm_ff;
            dreq.divisor  = RES_BITS'(ad_ff);
         end
         S_Q2_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = lcm_ff;
            dreq.divisor  = RES_BITS'(bd_ff);
         end
         S_SN_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = RES_BITS'(an_ff);
            dreq.divisor  = g_abs;
         end
         S_SD_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = RES_BITS'(ad_ff);
            dreq.divisor  = g_abs;
         end
         default: begin
            dreq.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff   <= req.command;
                  an_ff    <= req.a_num[OPERAND_WIDTH-1:0];
                  ad_ff    <= req.a_den[OPERAND_WIDTH-1:0];
                  bn_ff    <= req.b_num[OPERAND_WIDTH-1:0];
                  bd_ff    <= req.b_den[OPERAND_WIDTH-1:0];
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               num_ff   <= '0;
               den_ff   <= '0;
               state_ff <= S_DONE;
               case (cmd_ff)
                  CMD_ADD, CMD_SUB: begin
                     if (ad_ff != '0 && bd_ff != '0) begin
                        if (ad_ff == bd_ff) begin
                           num_ff <= (cmd_ff == CMD_ADD) ?
                              RES_BITS'(an_ff) + RES_BITS'(bn_ff) :
                              RES_BITS'(an_ff) - RES_BITS'(bn_ff);
                           den_ff <= RES_BITS'(ad_ff);
                        end else begin
                           gx_ff    <= RES_BITS'(ad_ff);
                           gy_ff    <= RES_BITS'(bd_ff);
                           state_ff <= S_GCD;
                        end
                     end
                  end
                  CMD_MUL, CMD_DIV: begin
                     state_ff <= S_XMUL1;
                  end
                  CMD_SIMPLIFY: begin
                     if (ad_ff == '0) begin
                        num_ff <= RES_BITS'(an_ff);
                     end else begin
                        gx_ff    <= RES_BITS'(an_ff);
                        gy_ff    <= RES_BITS'(ad_ff);
                        state_ff <= S_GCD;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_GCD: begin
               if (gy_ff == '0) begin
                  state_ff <= (cmd_ff == CMD_SIMPLIFY) ? S_SN_DIV : S_LCM_MUL;
               end else begin
                  state_ff <= S_GCD_WAIT;
               end
            end
            S_GCD_WAIT: begin
               if (drsp.done) begin
                  gx_ff    <= gy_ff;
                  gy_ff    <= drsp.remainder;
                  state_ff <= S_GCD;
               end
            end
            S_LCM_MUL: begin
               prod_ff  <= mul_res;
               state_ff <= S_LCM_DIV;
            end
            S_LCM_DIV: begin
               state_ff <= S_LCM_WAIT;
            end
            S_LCM_WAIT: begin
               if (drsp.done) begin
                  lcm_ff   <= drsp.quotient;
                  state_ff <= S_Q1_DIV;
               end
            end
            S_Q1_DIV: begin
               state_ff <= S_Q1_WAIT;
            end
            S_Q1_WAIT: begin
               if (drsp.done) begin
                  q_ff     <= drsp.quotient;
                  state_ff <= S_TA_MUL;
               end
            end
            S_TA_MUL: begin
               ta_ff    <= mul_res;
               state_ff <= S_Q2_DIV;
            end
            S_Q2_DIV: begin
               state_ff <= S_Q2_WAIT;
            end
            S_Q2_WAIT: begin
               if (drsp.done) begin
                  q_ff     <= drsp.quotient;
                  state_ff <= S_TB_MUL;
               end
            end
            S_TB_MUL: begin
               tb_ff    <= mul_res;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               num_ff   <= (cmd_ff == CMD_ADD) ? ta_ff + tb_ff : ta_ff - tb_ff;
               den_ff   <= lcm_ff;
               state_ff <= S_DONE;
            end
            S_XMUL1: begin
               num_ff   <= mul_res;
               state_ff <= S_XMUL2;
            end
            S_XMUL2: begin
               den_ff   <= mul_res;
               state_ff <= S_DONE;
            end
            S_SN_DIV: begin
               state_ff <= S_SN_WAIT;
            end
            S_SN_WAIT: begin
               if (drsp.done) begin
                  num_ff   <= drsp.quotient;
                  state_ff <= S_SD_DIV;
               end
            end
            S_SD_DIV: begin
               state_ff <= S_SD_WAIT;
            end
            S_SD_WAIT: begin
               if (drsp.done) begin
                  den_ff   <= drsp.quotient;
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               if (den_ff[RES_BITS-1]) begin
                  num_ff <= -num_ff;
                  den_ff <= -den_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_num_ff   <= num_ff;
                  rsp_den_ff   <= den_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req.ready     = state_ff == S_IDLE;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.res_num   = rsp_num_ff;
   assign rsp.res_den   = rsp_den_ff;
   assign rsp.res_valid = rsp_den_ff != '0;

endmodule

// ===== dv/rational_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 100ps

module rational_arithmetic_unit_core_tb;
   import rau_pkg::*;

   typedef struct {
      logic [CMD_BITS-1:0] command;
      logic signed [OPND_BITS-1:0] a_num;
      logic signed [OPND_BITS-1:0] a_den;
      logic signed [OPND_BITS-1:0] b_num;
      logic signed [OPND_BITS-1:0] b_den;
   } fraction_pair_t;

   typedef struct {
      logic signed [RES_BITS-1:0] res_num;
      logic signed [RES_BITS-1:0] res_den;
      logic res_valid;
   } fraction_result_t;

   localparam int TOTAL_WORDS = 1270;
   localparam int QUIET_TAIL = 150;
   localparam longint CYCLE_LIMIT = 20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if req ();
   rau_rsp_if rsp ();

   rational_arithmetic_unit_core dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   fraction_pair_t pending_words[$];
   fraction_result_t expected_results[$];
   fraction_pair_t word_on_bus;
   int errors = 0;
   int words_sent = 0;
   int results_seen = 0;
   int invalid_seen = 0;
   int send_gap = 0;
   int recv_gap = 0;
   longint cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint euclid_gcd(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_result_t predict_fraction(fraction_pair_t w);
      fraction_result_t r;
      longint an, ad, bn, bd, g, l, ta, tb, n, d;
      an = w.a_num;
      ad = w.a_den;
      bn = w.b_num;
      bd = w.b_den;
      r.res_num = 0;
      r.res_den = 0;
      case (w.command)
         CMD_ADD, CMD_SUB: begin
            if (ad != 0 && bd != 0) begin
               if (ad == bd) begin
                  ta = an;
                  tb = bn;
                  r.res_den = ad;
               end else begin
                  g = euclid_gcd(ad, bd);
                  l = (ad * bd) / g;
                  ta = (l / ad) * an;
                  tb = (l / bd) * bn;
                  r.res_den = l;
               end
               r.res_num = (w.command == CMD_ADD) ? ta + tb : ta - tb;
            end
         end
         CMD_MUL: begin
            r.res_num = an * bn;
            r.res_den = ad * bd;
         end
         CMD_DIV: begin
            r.res_num = an * bd;
            r.res_den = ad * bn;
         end
         CMD_SIMPLIFY: begin
            if (ad == 0) begin
               r.res_num = an;
            end else begin
               g = euclid_gcd(an, ad);
               if (g < 0) g = -g;
               n = an / g;
               d = ad / g;
               if (d < 0) begin
                  n = -n;
                  d = -d;
               end
               r.res_num = n;
               r.res_den = d;
            end
         end
         default: ;
      endcase
      r.res_valid = (r.res_den != 0);
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      int unsigned sel;
      logic [31:0] f;
      sel = $urandom_range(0, 9);
      f = $urandom_range(1, 60);
      case (sel)
         0, 1, 2: return 32'($signed($urandom_range(0, 200)) - 100);
         3, 4: return $urandom;
         5, 6: return f * 32'($signed($urandom_range(0, 2000)) - 1000);
         7: return 32'($signed($urandom_range(0, 65535)) - 32768);
         8: return {1'b1, 31'($urandom_range(0, 255))};
         default: return {1'b0, {23{1'b1}}, 8'($urandom)};
      endcase
   endfunction

   function automatic fraction_pair_t random_word();
      fraction_pair_t w;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      w.command = (sel < 96) ? CMD_BITS'(sel % 5) : CMD_BITS'($urandom_range(5, 7));
      w.a_num = pick_operand();
      w.a_den = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
      w.b_num = pick_operand();
      w.b_den = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
      if ($urandom_range(0, 7) == 0) w.b_den = w.a_den;
      return w;
   endfunction

   function automatic fraction_pair_t make_word(logic [CMD_BITS-1:0] c, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
      fraction_pair_t w;
      w.command = c;
      w.a_num = an;
      w.a_den = ad;
      w.b_num = bn;
      w.b_den = bd;
      return w;
   endfunction

   always @(posedge clock) begin
      logic fire;
      fire = req.valid && req.ready;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (fire) begin
            expected_results.push_back(predict_fraction(word_on_bus));
            words_sent++;
         end
         if (!req.valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               word_on_bus = pending_words.pop_front();
               req.command <= word_on_bus.command;
               req.a_num <= word_on_bus.a_num;
               req.a_den <= word_on_bus.a_den;
               req.b_num <= word_on_bus.b_num;
               req.b_den <= word_on_bus.b_den;
               req.valid <= 1'b1;
               if (words_sent < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 17);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      fraction_result_t exp_r;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (!rsp.res_valid) invalid_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result word: res_num %0d res_den %0d", rsp.res_num,
                      rsp.res_den);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp.res_num !== exp_r.res_num) begin
                  $error("res_num: expected %0d, actual %0d", exp_r.res_num, rsp.res_num);
                  errors++;
               end
               if (rsp.res_den !== exp_r.res_den) begin
                  $error("res_den: expected %0d, actual %0d", exp_r.res_den, rsp.res_den);
                  errors++;
               end
               if (rsp.res_valid !== exp_r.res_valid) begin
                  $error("res_valid: expected %0b, actual %0b", exp_r.res_valid,
                         rsp.res_valid);
                  errors++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (words_sent < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 4) == 0)
               recv_gap = $urandom_range(1, 17);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rational_arithmetic_unit_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [31:0] mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      req.valid = 1'b0;
      req.command = '0;
      req.a_num = '0;
      req.a_den = '0;
      req.b_num = '0;
      req.b_den = '0;
      rsp.ready = 1'b0;

      pending_words.push_back(make_word(CMD_ADD, 1, 2, 1, 3));
      pending_words.push_back(make_word(CMD_SUB, 5, 6, 7, 6));
      pending_words.push_back(make_word(CMD_ADD, mx, mx, mn, mn));
      pending_words.push_back(make_word(CMD_SUB, mn, mx, mx, mn));
      pending_words.push_back(make_word(CMD_ADD, 3, 0, 4, 5));
      pending_words.push_back(make_word(CMD_SUB, 3, 4, 4, 0));
      pending_words.push_back(make_word(CMD_ADD, 3, 0, 4, 0));
      pending_words.push_back(make_word(CMD_ADD, 7, -4, 1, 6));
      pending_words.push_back(make_word(CMD_MUL, mx, mn, mn, mn));
      pending_words.push_back(make_word(CMD_MUL, 0, 0, 5, 9));
      pending_words.push_back(make_word(CMD_DIV, mn, mx, mx, mn));
      pending_words.push_back(make_word(CMD_DIV, 3, 4, 0, 7));
      pending_words.push_back(make_word(CMD_SIMPLIFY, 12, 0, 1, 1));
      pending_words.push_back(make_word(CMD_SIMPLIFY, 0, -7, 1, 1));
      pending_words.push_back(make_word(CMD_SIMPLIFY, 6, -8, mx, mn));
      pending_words.push_back(make_word(CMD_SIMPLIFY, mn, -1, 0, 0));
      pending_words.push_back(make_word(CMD_SIMPLIFY, mn, mn, 0, 0));
      pending_words.push_back(make_word(CMD_SIMPLIFY, mx, 32'hffffffff, 0, 0));
      pending_words.push_back(make_word(3'd5, 1, 2, 3, 4));
      pending_words.push_back(make_word(3'd7, mx, mn, mx, mn));
      while (pending_words.size() < TOTAL_WORDS) pending_words.push_back(random_word());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4000) @(posedge clock);

      $display("Covered %0d fraction words, %0d results, %0d of them invalid.", words_sent,
               results_seen, invalid_seen);
      if (errors == 0 && expected_results.size() == 0)
         $display("rational_arithmetic_unit_core_tb: done, clean");
      else
         $display("rational_arithmetic_unit_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== rational_arithmetic_unit_core.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_div.sv
rtl/core/rational_arithmetic_unit_core.sv
dv/rational_arithmetic_unit_core_tb.sv
